FILE: rtl/core/cunrank_pkg.sv
// Shared types and constants for the combination unranker.
// Field widths, configuration register indexes, reset values and the walk FSM states.
package cunrank_pkg;

    localparam int RANK_W     = 38;
    localparam int BIN_W      = RANK_W + 1;   // binomial value plus saturation flag on top
    localparam int N_W        = 7;
    localparam int K_W        = 4;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_MAX_POSITIONS = 64;
    localparam int DEF_MAX_PICK      = 10;

    localparam logic [N_W-1:0] N_RESET = 7'd16;
    localparam logic [K_W-1:0] K_RESET = 4'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_POSITIONS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT      = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_EMIT,
        ST_ERR
    } t_walk_state;

endpackage

FILE: rtl/core/cunrank_binom_table.sv
// Binomial coefficient memory C(m, j), saturated at 2^38, with its Pascal fill sequencer.
// Filled once after reset, one entry per cycle; two registered read ports. Uses cunrank_pkg.
module cunrank_binom_table import cunrank_pkg::*; #(
    parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
    parameter int MAX_PICK      = DEF_MAX_PICK,
    parameter int MW            = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1,
    parameter int JW            = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_ready,
    input  logic [MW-1:0]    i_rd_m,
    input  logic [JW-1:0]    i_rd_j0,
    input  logic [JW-1:0]    i_rd_j1,
    output logic [BIN_W-1:0] o_rd0,
    output logic [BIN_W-1:0] o_rd1
);

    localparam int DEPTH = 2 ** (MW + JW);

    logic [BIN_W-1:0] r_mem [DEPTH];
    logic [BIN_W-1:0] r_row [MAX_PICK];
    logic [BIN_W-1:0] r_carry;
    logic [BIN_W-1:0] r_rd0;
    logic [BIN_W-1:0] r_rd1;
    logic [MW-1:0]    r_fm;
    logic [JW-1:0]    r_fj;
    logic             r_filling;

    logic [BIN_W-1:0] cin;
    logic [RANK_W:0]  sum;
    logic             sat;
    logic [BIN_W-1:0] val;
    logic             row_end;
    logic             fill_end;

    // Pascal step: C(m, j) = C(m-1, j) + C(m-1, j-1), the row walked with j ascending
    always_comb begin
        cin      = (r_fj == '0) ? '0 : r_carry;
        sum      = {1'b0, r_row[0][RANK_W-1:0]} + {1'b0, cin[RANK_W-1:0]};
        sat      = r_row[0][RANK_W] | cin[RANK_W] | sum[RANK_W];
        if (r_fm == '0) begin
            val = (r_fj == '0) ? BIN_W'(1) : '0;
        end else begin
            val = {sat, sum[RANK_W-1:0]};
        end
        row_end  = (r_fj == JW'(MAX_PICK - 1));
        fill_end = row_end && (r_fm == MW'(MAX_POSITIONS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling <= 1'b1;
            r_fm      <= '0;
            r_fj      <= '0;
        end else if (r_filling) begin
            if (row_end) begin
                r_fj <= '0;
                r_fm <= r_fm + MW'(1);
            end else begin
                r_fj <= r_fj + JW'(1);
            end
            if (fill_end) begin
                r_filling <= 1'b0;
            end
        end
    end

    // rotate the row so the entry being updated always sits at the head
    always_ff @(posedge i_clk) begin
        if (r_filling) begin
            r_carry <= r_row[0];
            for (int i = 0; i < MAX_PICK - 1; i++) begin
                r_row[i] <= r_row[i + 1];
            end
            r_row[MAX_PICK-1] <= val;
            r_mem[{r_fm, r_fj}] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[{i_rd_m, i_rd_j0}];
        r_rd1 <= r_mem[{i_rd_m, i_rd_j1}];
    end

    assign o_rd0   = r_rd0;
    assign o_rd1   = r_rd1;
    assign o_ready = !r_filling;

endmodule

FILE: rtl/core/cunrank_walker.sv
// Position walk sequencer: one binomial compare/subtract per position, result buffer, emit.
// Reads both candidate binomial entries for the coming step ahead of need. Uses cunrank_pkg.
module cunrank_walker import cunrank_pkg::*; #(
    parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
    parameter int MAX_PICK      = DEF_MAX_PICK,
    parameter int MW            = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1,
    parameter int JW            = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tbl_ready,
    input  logic              i_start,
    input  logic [N_W-1:0]    i_n,
    input  logic [K_W-1:0]    i_k,
    input  logic [RANK_W-1:0] i_rank,
    input  logic [BIN_W-1:0]  i_rd0,
    input  logic [BIN_W-1:0]  i_rd1,
    output logic [MW-1:0]     o_rd_m,
    output logic [JW-1:0]     o_rd_j0,
    output logic [JW-1:0]     o_rd_j1,
    output logic              o_busy,
    output logic              o_valid,
    output logic [POS_W-1:0]  o_position,
    output logic              o_last,
    output logic              o_error
);

    localparam int CW = $clog2(MAX_PICK + 1);
    localparam logic [N_W:0] N_LIM = (N_W + 1)'(MAX_POSITIONS);
    localparam logic [K_W:0] K_LIM = (K_W + 1)'(MAX_PICK);

    t_walk_state       r_state, n_state;
    logic [N_W-1:0]    r_rem,   n_rem;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [K_W-1:0]    r_need,  n_need;
    logic [RANK_W-1:0] r_rank,  n_rank;
    logic              r_dec,   n_dec;
    logic [CW-1:0]     r_cnt,   n_cnt;
    logic [CW-1:0]     r_ei,    n_ei;
    logic [POS_W-1:0]  r_buf [MAX_PICK];

    logic [BIN_W-1:0]  sel;
    logic [RANK_W:0]   diff;
    logic              take;
    logic              bad_req;
    logic              accept;
    logic [N_W-1:0]    m_off;
    logic              ei_last;

    assign o_busy  = (r_state != ST_IDLE) || !i_tbl_ready;
    assign accept  = i_start && !o_busy;
    assign bad_req = ({1'b0, i_n} > N_LIM) || ({1'b0, i_k} > K_LIM)
                     || (N_W'(i_k) > i_n) || ((i_k == '0) && (i_rank != '0));

    // pick the entry matching whether the previous step took its position
    assign sel  = r_dec ? i_rd1 : i_rd0;
    assign diff = {1'b0, r_rank} - {1'b0, sel[RANK_W-1:0]};
    assign take = sel[RANK_W] || diff[RANK_W];

    // prefetch for the coming step: row rem-1 in prime, rem-2 in walk, columns need-1 and need-2
    assign m_off   = (r_state == ST_PRIME) ? (r_rem - N_W'(1)) : (r_rem - N_W'(2));
    assign o_rd_m  = MW'(m_off);
    assign o_rd_j0 = JW'(r_need - K_W'(1));
    assign o_rd_j1 = (r_need >= K_W'(2)) ? JW'(r_need - K_W'(2)) : '0;

    assign ei_last = (r_ei == (r_cnt - CW'(1)));

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_pos   = r_pos;
        n_need  = r_need;
        n_rank  = r_rank;
        n_dec   = r_dec;
        n_cnt   = r_cnt;
        n_ei    = r_ei;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rem  = i_n;
                    n_need = i_k;
                    n_rank = i_rank;
                    n_pos  = '0;
                    n_cnt  = '0;
                    n_dec  = 1'b0;
                    if (bad_req) begin
                        n_state = ST_ERR;
                    end else if (i_k != '0) begin
                        n_state = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                n_pos = r_pos + POS_W'(1);
                n_rem = r_rem - N_W'(1);
                if (take) begin
                    n_need = r_need - K_W'(1);
                    n_cnt  = r_cnt + CW'(1);
                    n_dec  = 1'b1;
                end else begin
                    n_rank = diff[RANK_W-1:0];
                    n_dec  = 1'b0;
                end
                if ((n_rem == '0) || (n_need == '0)) begin
                    n_ei    = '0;
                    n_state = (n_need == '0) ? ST_EMIT : ST_ERR;
                end
            end
            ST_EMIT: begin
                n_ei = r_ei + CW'(1);
                if (ei_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dec   <= 1'b0;
            r_cnt   <= '0;
            r_ei    <= '0;
        end else begin
            r_state <= n_state;
            r_dec   <= n_dec;
            r_cnt   <= n_cnt;
            r_ei    <= n_ei;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_need <= n_need;
        r_rank <= n_rank;
        if ((r_state == ST_WALK) && take) begin
            r_buf[r_cnt[JW-1:0]] <= r_pos;
        end
    end

    assign o_valid    = (r_state == ST_EMIT) || (r_state == ST_ERR);
    assign o_position = (r_state == ST_EMIT) ? r_buf[r_ei[JW-1:0]] : '0;
    assign o_last     = (r_state == ST_ERR) || ((r_state == ST_EMIT) && ei_last);
    assign o_error    = (r_state == ST_ERR);

endmodule

FILE: rtl/core/combination_unranker.sv
// Combination unranker top: config registers, binomial table, position walker. Uses cunrank_pkg.
// Sequence: accept, a prime state, one walk step per position walked (at most n), then one
// result per cycle: k results, or one error result. The error comes right after accept for a
// bad configuration or a nonzero rank with k = 0, and after the walk for a rank out of range.
// Requests are taken one rank at a time, the walk paced by the single subtractor.
// Reset: synchronous; afterwards busy stays high while the binomial table fills all
// MAX_POSITIONS * MAX_PICK entries. Results are strobed for one cycle; the receiver cannot stall.
module combination_unranker import cunrank_pkg::*; #(
    parameter int MAX_POSITIONS = DEF_MAX_POSITIONS,
    parameter int MAX_PICK      = DEF_MAX_PICK
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [RANK_W-1:0]     i_rank,
    output logic                  o_valid,
    output logic [POS_W-1:0]      o_position,
    output logic                  o_last,
    output logic                  o_error
);

    localparam int MW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int JW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;

    logic [N_W-1:0]   r_total_positions;
    logic [K_W-1:0]   r_pick_count;
    logic             tbl_ready;
    logic [MW-1:0]    rd_m;
    logic [JW-1:0]    rd_j0;
    logic [JW-1:0]    rd_j1;
    logic [BIN_W-1:0] rd0;
    logic [BIN_W-1:0] rd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_positions <= N_RESET;
            r_pick_count      <= K_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TOTAL_POSITIONS: r_total_positions <= i_cfg_data[N_W-1:0];
                REG_PICK_COUNT:      r_pick_count      <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    cunrank_binom_table #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_PICK      (MAX_PICK),
        .MW            (MW),
        .JW            (JW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_ready (tbl_ready),
        .i_rd_m  (rd_m),
        .i_rd_j0 (rd_j0),
        .i_rd_j1 (rd_j1),
        .o_rd0   (rd0),
        .o_rd1   (rd1)
    );

    cunrank_walker #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_PICK      (MAX_PICK),
        .MW            (MW),
        .JW            (JW)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tbl_ready (tbl_ready),
        .i_start     (start),
        .i_n         (r_total_positions),
        .i_k         (r_pick_count),
        .i_rank      (i_rank),
        .i_rd0       (rd0),
        .i_rd1       (rd1),
        .o_rd_m      (rd_m),
        .o_rd_j0     (rd_j0),
        .o_rd_j1     (rd_j1),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_position  (o_position),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

FILE: rtl/core/cunrank_checker.sv
// Port-level checks on the combination unranker's result stream and busy flag.
// Bound to combination_unranker below; uses cunrank_pkg for the position width.
module cunrank_checker import cunrank_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic [POS_W-1:0] o_position,
    input logic             o_last,
    input logic             o_error
);

    // an error ends the request at once and carries no position
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && (o_position == '0)))
        else $error("error result without last or with a position");

    // a request ends with last and nothing follows in the next cycle
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result right after the last one");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result while not busy");

    // idle with no request stays silent
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_valid)
        else $error("result without a request");

endmodule

bind combination_unranker cunrank_checker u_cunrank_checker (.*);
